/* sv/yrd_pkg.sv */
// yrd_pkg: shared types, constants and ROM builders for yolo_region_decode.
// No dependencies. Used by yrd_rom and yolo_region_decode.
package yrd_pkg;

	localparam int ROM_DEPTH     = 1024;
	localparam int ROM_AW        = 10;
	localparam int SIG_W         = 16;
	localparam int EXP_W         = 28;
	localparam int LOGIT_W       = 16;
	localparam int BOX_FIELDS    = 5;
	localparam int ANCHOR_W      = 12;
	localparam int ANCHOR_PACK_W = 60;
	localparam int CFG_IDX_W     = 2;
	localparam int DIVIDEND_W    = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_ANCHOR_W  = 2'd1,
		CFG_ANCHOR_H  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_BOX0,
		ST_BOX1,
		ST_BOX2
	} seq_state_t;

	typedef logic [SIG_W-1:0] sig_tab_t [ROM_DEPTH];
	typedef logic [EXP_W-1:0] exp_tab_t [ROM_DEPTH];
	typedef logic [63:0] wide_tab_t [ROM_DEPTH+1];

	// shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// e^x in Q32.32 for x = (k - 512) / 64, k = 0..1024
	function automatic wide_tab_t build_wide();
		wide_tab_t w;
		logic [63:0] term;
		logic [63:0] up;
		logic [63:0] down;
		logic [63:0] acc;
		term = 64'd1 << 62;
		up   = term;
		down = term;
		for (int n = 1; n <= 12; n++) begin
			term = udiv64(term >> 6, 64'(n));
			up   = up + term;
			if ((n & 1) == 1) begin
				down = down - term;
			end else begin
				down = down + term;
			end
		end
		w[512] = 64'd1 << 32;
		acc = w[512];
		for (int k = 513; k <= ROM_DEPTH; k++) begin
			acc = mul_q62(acc, up);
			w[k] = acc;
		end
		acc = w[512];
		for (int k = 511; k >= 0; k--) begin
			acc = mul_q62(acc, down);
			w[k] = acc;
		end
		return w;
	endfunction

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t t;
		wide_tab_t w;
		logic [63:0] den;
		logic [63:0] s;
		w = build_wide();
		for (int k = 0; k < ROM_DEPTH; k++) begin
			den = (64'd1 << 32) + w[ROM_DEPTH-k];
			s = udiv64((64'd1 << 48) + (den >> 1), den);
			t[k] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
		end
		return t;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		wide_tab_t w;
		logic [63:0] r;
		w = build_wide();
		for (int k = 0; k < ROM_DEPTH; k++) begin
			r = w[k] + 64'd32768;
			t[k] = r[43:16];
		end
		return t;
	endfunction

	// Q6.10 argument to table index, clamped to the table range
	function automatic logic [ROM_AW-1:0] rom_idx(input logic signed [16:0] v);
		logic signed [17:0] t;
		t = {v[16], v} + 18'sd8192;
		if (t < 0) begin
			return '0;
		end else if (t[17:4] > 14'd1023) begin
			return '1;
		end else begin
			return t[13:4];
		end
	endfunction

endpackage

/* sv/yrd_rom.sv */
// yrd_rom: sigmoid and exp lookup tables with registered read ports.
// Depends on yrd_pkg for table builders and widths.
module yrd_rom (
	input  logic                      clk,
	input  logic [yrd_pkg::ROM_AW-1:0] sig_addr,
	input  logic [yrd_pkg::ROM_AW-1:0] exp_addr,
	output logic [yrd_pkg::SIG_W-1:0]  sig_data,
	output logic [yrd_pkg::EXP_W-1:0]  exp_data
);
	import yrd_pkg::*;

	localparam sig_tab_t SIG_TAB = build_sig_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

	logic [SIG_W-1:0] sig_q;
	logic [EXP_W-1:0] exp_q;

	always_ff @(posedge clk) begin
		sig_q <= SIG_TAB[sig_addr];
		exp_q <= EXP_TAB[exp_addr];
	end

	assign sig_data = sig_q;
	assign exp_data = exp_q;

endmodule

/* sv/yolo_region_decode.sv */
// yolo_region_decode: YOLOv2 region record decoder, sequenced over one shared datapath.
// Depends on yrd_pkg and yrd_rom.
//
// channel   direction  handshake         payload
// item      in         start & !busy     raw_value, elem_index, cell_x, cell_y, anchor_sel
// result    out        done (1 cycle)    box_cx, box_cy, box_width, box_height,
//                                        box_score, box_class
// config    in         cfg_we            cfg_index, cfg_data
//
// Elements are taken one per cycle while busy is low. The last class logit starts a
// decode: softmax sum walk, divider, then the box states (only BOX0 on a fail);
// busy is high meanwhile; a passing record raises done in the first idle cycle after.
// Results cannot be stalled. Reset returns the sequencer to idle and the control, config
// and output registers to their defaults; the logit stores are not reset.
module yolo_region_decode #(
	parameter int NUM_CLASS  = 20,
	parameter int NUM_ANCHOR = 5
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [yrd_pkg::LOGIT_W-1:0]     raw_value,
	input  logic [4:0]                             elem_index,
	input  logic [4:0]                             cell_x,
	input  logic [4:0]                             cell_y,
	input  logic [2:0]                             anchor_sel,
	input  logic                                   cfg_we,
	input  logic [yrd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [yrd_pkg::ANCHOR_PACK_W-1:0]      cfg_data,
	output logic                                   done,
	output logic [20:0]                            box_cx,
	output logic [20:0]                            box_cy,
	output logic [15:0]                            box_width,
	output logic [15:0]                            box_height,
	output logic [15:0]                            box_score,
	output logic [5:0]                             box_class
);
	import yrd_pkg::*;

	localparam int CW    = (NUM_CLASS > 1) ? $clog2(NUM_CLASS) : 1;
	localparam int SUM_W = EXP_W + $clog2(NUM_CLASS + 1);

	seq_state_t state_q, state_d;

	logic [15:0]              thr_q;
	logic [ANCHOR_PACK_W-1:0] anchor_w_q;
	logic [ANCHOR_PACK_W-1:0] anchor_h_q;

	logic signed [LOGIT_W-1:0] box_q [BOX_FIELDS];
	logic [LOGIT_W-1:0]        cls_mem [NUM_CLASS];
	logic signed [LOGIT_W-1:0] max_logit_q;
	logic [5:0]                best_class_q;

	logic [4:0] rec_cx_q;
	logic [4:0] rec_cy_q;
	logic [2:0] rec_anchor_q;

	logic [CW:0]               rd_cnt_q;
	logic                      rd_v_s1;
	logic                      exp_v_s2;
	logic signed [LOGIT_W-1:0] mem_rd_s1;
	logic [SUM_W-1:0]          sum_q;
	logic [SIG_W-1:0]          obj_q;
	logic [4:0]                div_cnt_q;
	logic [SUM_W-1:0]          rem_q;
	logic [DIVIDEND_W-1:0]     quo_q;
	logic                      done_q;

	logic [20:0] cx_q, cy_q;
	logic [15:0] w_q, h_q, score_q;
	logic [5:0]  cls_out_q;

	logic              accept;
	logic              is_box;
	logic [5:0]        cls_idx;
	logic              is_cls;
	logic              is_last;
	logic [2:0]        anchor_clamp;
	logic              seq_issue;
	logic              sum_done;
	logic              pass;
	logic [15:0]       score;
	logic [ROM_AW-1:0] sig_addr, exp_addr;
	logic [SIG_W-1:0]  sig_data;
	logic [EXP_W-1:0]  exp_data;
	logic [SUM_W:0]    trial;
	logic              trial_ge;
	logic [SUM_W:0]    trial_sub;
	logic [ANCHOR_W-1:0] mul_a;
	logic [39:0]       prod;
	logic [39:0]       prod_rnd;
	logic [15:0]       size_sat;
	logic [20:0]       center_sum;

	assign accept  = start & ~busy;
	assign is_box  = elem_index < 5'd5;
	assign cls_idx = {1'b0, elem_index} - 6'd5;
	assign is_cls  = ~is_box && ({1'b0, cls_idx} < 7'(NUM_CLASS));
	assign is_last = is_cls && ({1'b0, cls_idx} == 7'(NUM_CLASS - 1));
	assign anchor_clamp = (anchor_sel >= 3'(NUM_ANCHOR)) ? 3'(NUM_ANCHOR - 1) : anchor_sel;

	assign sum_done = (rd_cnt_q == (CW+1)'(NUM_CLASS)) && !rd_v_s1 && !exp_v_s2;
	assign score = (sum_q == '0) ? 16'd0 :
		((quo_q[31:16] != 16'd0) ? 16'hFFFF : quo_q[15:0]);
	assign pass = (obj_q >= thr_q) && (score >= thr_q);

	assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial_ge  = trial >= {1'b0, sum_q};
	assign trial_sub = trial - {1'b0, sum_q};

	assign mul_a    = (state_q == ST_BOX1) ? anchor_w_q[ANCHOR_W*rec_anchor_q +: ANCHOR_W]
	                                       : anchor_h_q[ANCHOR_W*rec_anchor_q +: ANCHOR_W];
	assign prod     = {28'd0, mul_a} * {12'd0, exp_data};
	assign prod_rnd = prod + 40'd32768;
	assign size_sat = (prod_rnd[39:32] != 8'd0) ? 16'hFFFF : prod_rnd[31:16];
	assign center_sum = {((state_q == ST_BOX1) ? rec_cx_q : rec_cy_q), 16'd0}
		+ {5'd0, sig_data};

	yrd_rom u_rom (
		.clk      (clk),
		.sig_addr (sig_addr),
		.exp_addr (exp_addr),
		.sig_data (sig_data),
		.exp_data (exp_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		seq_issue = 1'b0;
		busy      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept && is_last) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				seq_issue = rd_cnt_q < (CW+1)'(NUM_CLASS);
				if (sum_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == '1) begin
					state_d = ST_BOX0;
				end
			end
			ST_BOX0: state_d = pass ? ST_BOX1 : ST_IDLE;
			ST_BOX1: state_d = ST_BOX2;
			ST_BOX2: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_BOX0: begin
				sig_addr = rom_idx({box_q[0][15], box_q[0]});
				exp_addr = rom_idx({box_q[2][15], box_q[2]});
			end
			ST_BOX1: begin
				sig_addr = rom_idx({box_q[1][15], box_q[1]});
				exp_addr = rom_idx({box_q[3][15], box_q[3]});
			end
			default: begin
				sig_addr = rom_idx({box_q[4][15], box_q[4]});
				exp_addr = rom_idx({mem_rd_s1[15], mem_rd_s1} - {max_logit_q[15], max_logit_q});
			end
		endcase
	end

	// configuration and running max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= 16'd19661;
			anchor_w_q   <= '0;
			anchor_h_q   <= '0;
			max_logit_q  <= '0;
			best_class_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_THRESHOLD: thr_q      <= cfg_data[15:0];
					CFG_ANCHOR_W:  anchor_w_q <= cfg_data;
					CFG_ANCHOR_H:  anchor_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && is_cls && (cls_idx == 6'd0 || raw_value > max_logit_q)) begin
				max_logit_q  <= raw_value;
				best_class_q <= cls_idx;
			end
		end
	end

	// logit stores and record fields
	always_ff @(posedge clk) begin
		if (accept && is_box) begin
			box_q[elem_index[2:0]] <= raw_value;
		end
		if (accept && is_cls) begin
			cls_mem[cls_idx[CW-1:0]] <= raw_value;
		end
		if (accept && is_last) begin
			rec_cx_q     <= cell_x;
			rec_cy_q     <= cell_y;
			rec_anchor_q <= anchor_clamp;
		end
		if (seq_issue) begin
			mem_rd_s1 <= cls_mem[rd_cnt_q[CW-1:0]];
		end
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_v_s1   <= 1'b0;
			exp_v_s2  <= 1'b0;
			div_cnt_q <= '0;
			done_q    <= 1'b0;
			sum_q     <= '0;
			obj_q     <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			w_q       <= '0;
			h_q       <= '0;
			score_q   <= '0;
			cls_out_q <= '0;
		end else begin
			done_q   <= 1'b0;
			rd_v_s1  <= seq_issue;
			exp_v_s2 <= rd_v_s1;
			case (state_q)
				ST_IDLE: begin
					rd_cnt_q <= '0;
					sum_q    <= '0;
				end
				ST_SUM: begin
					if (seq_issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (exp_v_s2) begin
						sum_q <= sum_q + {{(SUM_W-EXP_W){1'b0}}, exp_data};
					end
					if (sum_done) begin
						obj_q     <= sig_data;
						quo_q     <= {sig_data, 16'd0};
						rem_q     <= '0;
						div_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					rem_q     <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
					quo_q     <= {quo_q[DIVIDEND_W-2:0], trial_ge};
				end
				ST_BOX1: begin
					cx_q <= center_sum;
					w_q  <= size_sat;
				end
				ST_BOX2: begin
					cy_q      <= center_sum;
					h_q       <= size_sat;
					score_q   <= score;
					cls_out_q <= best_class_q;
					done_q    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign done       = done_q;
	assign box_cx     = cx_q;
	assign box_cy     = cy_q;
	assign box_width  = w_q;
	assign box_height = h_q;
	assign box_score  = score_q;
	assign box_class  = cls_out_q;

endmodule
